// File: rtl/core/alarm_beep_cadence_sequencer_macros.svh
// Assertion macros used by the sequencer core RTL.
`ifndef ALARM_BEEP_CADENCE_SEQUENCER_MACROS_SVH
`define ALARM_BEEP_CADENCE_SEQUENCER_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ABCS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under synchronous reset.
`define ABCS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/abcs_pkg.sv
package abcs_pkg;

   localparam int PATTERN_STEPS = 8;
   localparam int STEP_W        = $clog2(PATTERN_STEPS);
   localparam int CSR_ADDR_W    = 5;
   localparam int REG_IDX_W     = CSR_ADDR_W - 2;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_SHORT_ON    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_OFF   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LONG_ON     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_LONG_OFF    = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TONE_PERIOD = 3'd4;

   localparam logic [15:0] RST_SHORT_ON    = 16'd120;
   localparam logic [15:0] RST_SHORT_OFF   = 16'd90;
   localparam logic [15:0] RST_LONG_ON     = 16'd320;
   localparam logic [15:0] RST_LONG_OFF    = 16'd450;
   localparam logic [15:0] RST_TONE_PERIOD = 16'd4000;
   localparam logic [15:0] MIN_PERIOD      = 16'd2;

   typedef struct packed {
      logic [15:0] short_on_ms;
      logic [15:0] short_off_ms;
      logic [15:0] long_on_ms;
      logic [15:0] long_off_ms;
      logic [15:0] tone_period;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic        tone_on;
      logic        alarm_on;
      logic [2:0]  step_index;
      logic [15:0] reload_value;
      logic [14:0] compare_value;
   } res_type;

   function automatic logic [15:0] step_duration(input logic [STEP_W-1:0] s,
                                                 input cfg_type c);
      logic [15:0] d;
      if (s == STEP_W'(PATTERN_STEPS - 1)) begin
         d = c.long_off_ms;
      end else if (s == STEP_W'(PATTERN_STEPS - 2)) begin
         d = c.long_on_ms;
      end else if (s[0] == 1'b0) begin
         d = c.short_on_ms;
      end else begin
         d = c.short_off_ms;
      end
      return d;
   endfunction

endpackage

// File: rtl/core/abcs_csr.sv
module abcs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [abcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output abcs_pkg::cfg_type                cfg
);
   import abcs_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_SHORT_ON:    cfg_in.short_on_ms  = csr_pwdata[15:0];
            REG_SHORT_OFF:   cfg_in.short_off_ms = csr_pwdata[15:0];
            REG_LONG_ON:     cfg_in.long_on_ms   = csr_pwdata[15:0];
            REG_LONG_OFF:    cfg_in.long_off_ms  = csr_pwdata[15:0];
            REG_TONE_PERIOD: cfg_in.tone_period  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_SHORT_ON:    csr_prdata = {16'd0, cfg_ff.short_on_ms};
         REG_SHORT_OFF:   csr_prdata = {16'd0, cfg_ff.short_off_ms};
         REG_LONG_ON:     csr_prdata = {16'd0, cfg_ff.long_on_ms};
         REG_LONG_OFF:    csr_prdata = {16'd0, cfg_ff.long_off_ms};
         REG_TONE_PERIOD: csr_prdata = {16'd0, cfg_ff.tone_period};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_on_ms  <= RST_SHORT_ON;
         cfg_ff.short_off_ms <= RST_SHORT_OFF;
         cfg_ff.long_on_ms   <= RST_LONG_ON;
         cfg_ff.long_off_ms  <= RST_LONG_OFF;
         cfg_ff.tone_period  <= RST_TONE_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/abcs_core.sv
`include "alarm_beep_cadence_sequencer_macros.svh"

module abcs_core (
   input  logic               clock,
   input  logic               reset,
   input  abcs_pkg::cfg_type  cfg,
   input  abcs_pkg::item_type item,
   input  logic               item_fire,
   output abcs_pkg::res_type  res
);
   import abcs_pkg::*;

   logic              active_ff;
   logic              active_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [STEP_W-1:0] step_next;
   logic [31:0]       deadline_ff;
   logic [31:0]       deadline_in;
   logic [31:0]       diff;
   logic              reached;
   logic [15:0]       period;
   logic [STEP_W+2:0] step_ext;

   assign diff      = item.now_ms - deadline_ff;
   assign reached   = ~diff[31];
   assign step_next = (step_ff == STEP_W'(PATTERN_STEPS - 1)) ? '0 : step_ff + STEP_W'(1);

   always_comb begin
      active_in   = active_ff;
      step_in     = step_ff;
      deadline_in = deadline_ff;
      case (item.kind)
         KIND_START: begin
            active_in   = 1'b1;
            step_in     = '0;
            deadline_in = item.now_ms + {16'd0, step_duration('0, cfg)};
         end
         KIND_STOP: begin
            active_in = 1'b0;
         end
         KIND_TICK: begin
            if (active_ff && reached) begin
               step_in     = step_next;
               deadline_in = item.now_ms + {16'd0, step_duration(step_next, cfg)};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         step_ff     <= '0;
         deadline_ff <= 32'd0;
      end else if (item_fire) begin
         active_ff   <= active_in;
         step_ff     <= step_in;
         deadline_ff <= deadline_in;
      end
   end

   assign period   = (cfg.tone_period < MIN_PERIOD) ? MIN_PERIOD : cfg.tone_period;
   assign step_ext = {3'd0, step_in};

   assign res.tone_on       = active_in & ~step_in[0];
   assign res.alarm_on      = active_in;
   assign res.step_index    = step_ext[2:0];
   assign res.reload_value  = period - 16'd1;
   assign res.compare_value = period[15:1];

   `ABCS_ASSERT_NXT(a_start_rewinds, clock, reset, item_fire && item.kind == KIND_START,
      active_ff && step_ff == '0, "start did not rewind the cadence")
   `ABCS_ASSERT_NXT(a_stop_keeps_step, clock, reset, item_fire && item.kind == KIND_STOP,
      !active_ff && step_ff == $past(step_ff), "stop changed the step or kept active")
   `ABCS_ASSERT_NXT(a_idle_holds, clock, reset, !item_fire,
      $stable(step_ff) && $stable(deadline_ff) && $stable(active_ff), "state moved without a word")
   `ABCS_ASSERT_IMP(a_step_range, clock, reset, 1'b1,
      step_ff <= STEP_W'(PATTERN_STEPS - 1), "cadence step out of range")

endmodule

// File: rtl/core/alarm_beep_cadence_sequencer.sv
// A request word accepted into the input register yields its response word from the result register.
// Throughput: one word per cycle unless rsp_tready stalls; one input and one result register.
// The cadence state updates as a word moves from the input register into the result register.
// Reset (synchronous, active high) empties both registers, clears the cadence state
// and loads the register defaults; no clearing pass is needed.
module alarm_beep_cadence_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [31:0]                      req_tdata,   // now_ms
   input  logic [1:0]                       req_tuser,   // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tone_on, alarm_on, step_index[2:0], reload_value[15:0], compare_value[14:0], pad
   output logic [39:0]                      rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [abcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import abcs_pkg::*;

   cfg_type  cfg;
   item_type in_item_ff;
   logic     in_valid_ff;
   res_type  res;
   res_type  out_res_ff;
   logic     out_valid_ff;
   logic     adv;

   abcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   abcs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (in_item_ff),
      .item_fire (adv),
      .res       (res)
   );

   assign adv        = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind   <= req_tuser;
         in_item_ff.now_ms <= req_tdata;
      end
      if (adv) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_res_ff.compare_value, out_res_ff.reload_value,
                        out_res_ff.step_index, out_res_ff.alarm_on, out_res_ff.tone_on};

endmodule
